// ===== rtl/core/plf_pkg.sv =====
// plf_pkg: shared widths, register indexes, ramp mode codes and the
// controller/datapath command and status structs for the PCM linear fader.
// No dependencies.
package plf_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int LEN_W             = 24;
   localparam int MODE_W            = 2;
   localparam int CSR_IDX_W         = 1;
   localparam int PROD_W            = SAMPLE_W + LEN_W;
   localparam int DIV_STEPS         = SAMPLE_W;
   localparam int STEP_CNT_W        = $clog2(DIV_STEPS);
   localparam int POSITION_BITS_DEF = 24;

   // ramp modes
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OUT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FADE_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_LENGTH = 1'b1;

   typedef struct packed {
      logic take;      // sample accepted this cycle
      logic mul;       // form magnitude times gain numerator
      logic step;      // one restoring division step
      logic out_load;  // move the finished result into the output register
   } cmd_type;

   typedef struct packed {
      logic scale_req; // the offered sample needs the multiply/divide path
   } sts_type;

endpackage

// ===== rtl/core/plf_ctrl.sv =====
// plf_ctrl: sequencing state machine of the PCM linear fader.
// Drives the datapath through plf_pkg::cmd_type and owns the result valid flag.
// Depends on plf_pkg.
module plf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  plf_pkg::sts_type  sts,
   output plf_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [plf_pkg::STEP_CNT_W-1:0] STEP_LAST =
      plf_pkg::STEP_CNT_W'(plf_pkg::DIV_STEPS - 1);

   logic [1:0]                      state_ff, state_in;
   logic [plf_pkg::STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            valid_ff, valid_in;
   logic                            take;
   logic                            out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_DONE) && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = sts.scale_req ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      cmd.take     = take;
      cmd.mul      = (state_ff == ST_MUL);
      cmd.step     = (state_ff == ST_DIV);
      cmd.out_load = out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/plf_datapath.sv =====
// plf_datapath: fade registers, ramp position, gain multiply, serial
// restoring divider and the result register of the PCM linear fader.
// Depends on plf_pkg; sequenced by plf_ctrl.
module plf_datapath #(
   parameter int POSITION_BITS = plf_pkg::POSITION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [plf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [plf_pkg::LEN_W-1:0]             csr_data,
   input  logic signed [plf_pkg::SAMPLE_W-1:0]   req_sample,
   input  plf_pkg::cmd_type                      cmd,
   output plf_pkg::sts_type                      sts,
   output logic signed [plf_pkg::SAMPLE_W-1:0]   rsp_sample,
   output logic                                  rsp_active,
   output logic                                  rsp_closed
);

   localparam int SW    = plf_pkg::SAMPLE_W;
   localparam int LW    = plf_pkg::LEN_W;
   localparam int PW    = plf_pkg::PROD_W;
   localparam int CMP_W = (POSITION_BITS > LW) ? POSITION_BITS : LW;

   // architectural state
   logic [plf_pkg::MODE_W-1:0] ramp_ff, ramp_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic                       closed_ff, closed_in;
   logic [LW-1:0]              len_ff, len_in;

   // per-item working registers
   logic                       neg_ff;
   logic [SW-1:0]              mag_ff;
   logic [LW-1:0]              num_ff;
   logic                       scale_ff;
   logic [SW-1:0]              res_ff;
   logic                       active_ff;
   logic [PW-1:0]              work_ff, work_in;

   // result register
   logic [SW-1:0]              out_sample_ff;
   logic                       out_active_ff;
   logic                       out_closed_ff;

   logic [CMP_W-1:0]           pos_ext;
   logic [CMP_W-1:0]           len_ext;
   logic                       ramp_end;
   logic [LW-1:0]              num_calc;
   logic [SW-1:0]              mag_calc;
   logic [SW-1:0]              res_calc;
   logic                       active_calc;
   logic                       scale_calc;
   logic [LW:0]                trial;
   logic [LW:0]                diff;
   logic                       qbit;
   logic [SW-1:0]              quot;
   logic [SW-1:0]              scaled;

   assign pos_ext  = CMP_W'(pos_ff);
   assign len_ext  = CMP_W'(len_ff);
   assign ramp_end = (pos_ext >= len_ext);
   assign mag_calc = req_sample[SW-1] ? SW'(-req_sample) : SW'(req_sample);

   // decision for the offered sample, from the state before it; else register writes
   always_comb begin
      ramp_in     = ramp_ff;
      pos_in      = pos_ff;
      closed_in   = closed_ff;
      len_in      = len_ff;
      res_calc    = SW'(req_sample);
      active_calc = 1'b0;
      scale_calc  = 1'b0;
      num_calc    = (ramp_ff == plf_pkg::MODE_IN) ? pos_ext[LW-1:0]
                                                  : len_ff - pos_ext[LW-1:0];
      if (cmd.take) begin
         if (closed_ff) begin
            res_calc = '0;
         end else if (ramp_ff != plf_pkg::MODE_NONE) begin
            if (ramp_end) begin
               if (ramp_ff == plf_pkg::MODE_OUT) begin
                  res_calc  = '0;
                  closed_in = 1'b1;
               end
               ramp_in = plf_pkg::MODE_NONE;
            end else begin
               active_calc = 1'b1;
               scale_calc  = 1'b1;
               if (pos_ff != {POSITION_BITS{1'b1}}) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
      end else if (csr_write) begin
         case (csr_index)
            plf_pkg::REG_FADE_MODE: begin
               pos_in = '0;
               case (csr_data[plf_pkg::MODE_W-1:0])
                  plf_pkg::MODE_IN:
                     ramp_in = (len_ff != '0) ? plf_pkg::MODE_IN : plf_pkg::MODE_NONE;
                  plf_pkg::MODE_OUT: ramp_in = plf_pkg::MODE_OUT;
                  default:           ramp_in = plf_pkg::MODE_NONE;
               endcase
            end
            plf_pkg::REG_FADE_LENGTH: len_in = csr_data;
            default: len_in = len_ff;
         endcase
      end
   end

   // the decision is only meaningful for a ramped, unfinished, open source
   assign sts.scale_req = !closed_ff && (ramp_ff != plf_pkg::MODE_NONE) && !ramp_end;

   // multiply, then one quotient bit per step; quotient fits SW bits as num <= len
   assign trial = {work_ff[PW-1:SW], work_ff[SW-1]};
   assign diff  = trial - {1'b0, len_ff};
   assign qbit  = !diff[LW];
   assign quot  = work_ff[SW-1:0];
   assign scaled = neg_ff ? SW'(-quot) : quot;

   always_comb begin
      work_in = work_ff;
      if (cmd.mul) begin
         work_in = PW'(mag_ff * num_ff);
      end else if (cmd.step) begin
         work_in = {(qbit ? diff[LW-1:0] : trial[LW-1:0]), work_ff[SW-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff   <= plf_pkg::MODE_NONE;
         pos_ff    <= '0;
         closed_ff <= 1'b0;
         len_ff    <= '0;
      end else begin
         ramp_ff   <= ramp_in;
         pos_ff    <= pos_in;
         closed_ff <= closed_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (cmd.take) begin
         neg_ff    <= req_sample[SW-1];
         mag_ff    <= mag_calc;
         num_ff    <= num_calc;
         scale_ff  <= scale_calc;
         res_ff    <= res_calc;
         active_ff <= active_calc;
      end
      if (cmd.out_load) begin
         out_sample_ff <= scale_ff ? scaled : res_ff;
         out_active_ff <= active_ff;
         out_closed_ff <= closed_ff;
      end
   end

   assign rsp_sample = signed'(out_sample_ff);
   assign rsp_active = out_active_ff;
   assign rsp_closed = out_closed_ff;

endmodule

// ===== rtl/core/pcm_linear_fader_unit.sv =====
// pcm_linear_fader_unit: top level of the PCM linear fader.
// Joins plf_ctrl and plf_datapath; depends on plf_pkg.
//
// Usage:
//  - req_* carries one signed 16-bit PCM sample per transaction in req_tdata.
//  - rsp_* returns exactly one result per sample: the scaled sample in
//    rsp_tdata, fade_active and closed flags in rsp_tuser.
//  - csr_* writes registers: index 0 fade_mode (0 none, 1 in, 2 out, restarts
//    the ramp position), index 1 fade_length in samples. csr_ready is always
//    high; write only while no sample is in flight.
//  - Timing: a ramped sample passes through a multiply, the 16-step serial
//    restoring divider and a load into the output register before its result
//    reaches rsp_*; any other sample goes straight to the load. The next
//    transaction is taken the cycle after the load, so one sample is in flight
//    at a time.
//  - The result sits in an output register, so the next sample is accepted
//    while the previous result still waits; a stalled receiver holds rsp_*
//    and a finished result then waits in the datapath until the slot frees.
//  - Reset clears the mode, length, position and closed flag and drops any
//    pending result. Once a fade-out completes the source stays silenced
//    until reset.
module pcm_linear_fader_unit #(
   parameter int POSITION_BITS = plf_pkg::POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input samples
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // [15:0] sample
   // results
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // [15:0] out_sample
   output logic [1:0]                      rsp_tuser,  // [0] fade_active, [1] closed
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [plf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [plf_pkg::LEN_W-1:0]       csr_data
);

   plf_pkg::cmd_type                     cmd;
   plf_pkg::sts_type                     sts;
   logic signed [plf_pkg::SAMPLE_W-1:0]  out_sample;
   logic                                 out_active;
   logic                                 out_closed;

   // writes land in the datapath directly; take them every cycle
   assign csr_ready = 1'b1;

   plf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   plf_datapath #(
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_sample (signed'(req_tdata)),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_sample (out_sample),
      .rsp_active (out_active),
      .rsp_closed (out_closed)
   );

   assign rsp_tdata = unsigned'(out_sample);
   assign rsp_tuser = {out_closed, out_active};

endmodule

// ===== rtl/core/plf_checker.sv =====
// plf_checker: port-level assertions for pcm_linear_fader_unit, with its bind.
// Sees only the top-level ports; depends on nothing else.
module plf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // drop any pending result on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one sample in flight: no transaction right after a transaction
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken while one is in flight");

   // a closed source is silent and no ramp is reported
   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 16'd0 && !rsp_tuser[0])
      else $error("closed source produced sound or active ramp");

endmodule

bind pcm_linear_fader_unit plf_checker u_plf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
